// ===== rtl/core/pnc_pkg.sv =====
// Shared types, codes and constants for the palette nearest-color block.
package pnc_pkg;

  localparam int PALETTE_SIZE_DEF = 256;
  localparam int DIST_W = 18;
  localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

  localparam logic [1:0] KIND_FIND  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [7:0]        found_index;
    logic [DIST_W-1:0] best_distance;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
  } result_t;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  localparam int BOOT_COUNT = 16;
  localparam rgb_t BOOT_COLORS [BOOT_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'hC0C0C0, 24'h808080,
    24'hFF0000, 24'h800000, 24'h00FF00, 24'h008000,
    24'h0000FF, 24'h000080, 24'hFFFF00, 24'h808000,
    24'h00FFFF, 24'h008080, 24'hFF00FF, 24'h800080
  };

endpackage

// ===== rtl/core/pnc_mem.sv =====
// Palette storage: one write port, one read port with registered read data.
module pnc_mem #(
  parameter int DEPTH = pnc_pkg::PALETTE_SIZE_DEF,
  parameter int AW    = $clog2(pnc_pkg::PALETTE_SIZE_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pnc_pkg::rgb_t    wdata,
  input  logic [AW-1:0]    raddr,
  output pnc_pkg::rgb_t    rdata
);

  pnc_pkg::rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pnc_dist.sv =====
// Two-stage squared RGB distance unit; index and color ride along as a tag.
module pnc_dist #(
  parameter int AW = $clog2(pnc_pkg::PALETTE_SIZE_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pnc_pkg::beat_ctl_t          in_ctl,
  input  logic [AW-1:0]               in_idx,
  input  pnc_pkg::rgb_t               in_color,
  input  pnc_pkg::rgb_t               query,
  output pnc_pkg::beat_ctl_t          out_ctl,
  output logic [AW-1:0]               out_idx,
  output pnc_pkg::rgb_t               out_color,
  output logic [pnc_pkg::DIST_W-1:0]  out_dist
);

  logic [7:0]         diff_r, diff_g, diff_b;
  logic [15:0]        sq_r, sq_g, sq_b;
  pnc_pkg::beat_ctl_t s1_ctl;
  logic [AW-1:0]      s1_idx;
  pnc_pkg::rgb_t      s1_color;

  always_comb begin
    diff_r = (in_color.red > query.red) ? in_color.red - query.red
                                        : query.red - in_color.red;
    diff_g = (in_color.green > query.green) ? in_color.green - query.green
                                            : query.green - in_color.green;
    diff_b = (in_color.blue > query.blue) ? in_color.blue - query.blue
                                          : query.blue - in_color.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      out_ctl <= '0;
    end else begin
      s1_ctl  <= in_ctl;
      out_ctl <= s1_ctl;
    end
  end

  // square each component, then sum
  always_ff @(posedge clk) begin
    sq_r      <= diff_r * diff_r;
    sq_g      <= diff_g * diff_g;
    sq_b      <= diff_b * diff_b;
    s1_idx    <= in_idx;
    s1_color  <= in_color;
    out_dist  <= pnc_pkg::DIST_W'(sq_r) + pnc_pkg::DIST_W'(sq_g)
               + pnc_pkg::DIST_W'(sq_b);
    out_idx   <= s1_idx;
    out_color <= s1_color;
  end

endmodule

// ===== rtl/core/palette_nearest_color.sv =====
// Top level of the palette nearest-color block: control, search and result register.
//
// The block keeps PALETTE_SIZE RGB888 colors in one single-port-read palette
// memory. Each beat on the item channel writes one entry, reads one entry back,
// or looks for the entry with the smallest squared RGB distance to a query
// color; ties go to the lowest index. After reset the block runs a clearing
// pass that loads the sixteen standard colors followed by black: item_ready
// stays low until that pass ends. A find walks the palette one entry per
// cycle through the memory read port and the distance unit; a read waits
// in a read state for the read data, and a write, an out-of-range read or
// an unused kind goes straight to the done state. One item is worked on at a
// time, but the result sits in its own register, so the next item is accepted
// while the previous result waits for result_ready. Entries at index 256 and
// up (larger palettes only) cannot be written, stay black and are still
// searched; found_index then carries the low 8 bits of the winning index.
module palette_nearest_color #(
  parameter int PALETTE_SIZE = pnc_pkg::PALETTE_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pnc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pnc_pkg::result_t result
);

  localparam int AW = $clog2(PALETTE_SIZE);
  localparam int CW = $clog2(PALETTE_SIZE + 1);
  localparam int IW = (CW > 8) ? CW : 8;

  pnc_pkg::state_t state, state_next;

  // shared counter: clearing pass address and scan address
  logic [CW-1:0] scan_cnt;
  logic          issue;
  logic          accept;
  logic          load_out;

  logic [IW-1:0] item_idx_w;
  logic          item_in_range;
  logic [AW-1:0] item_addr;
  logic          item_wr_hit;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pnc_pkg::rgb_t mem_wdata;
  logic [AW-1:0] mem_raddr;
  pnc_pkg::rgb_t mem_rdata;

  pnc_pkg::beat_ctl_t rd_ctl;
  logic [AW-1:0]      rd_idx;

  pnc_pkg::beat_ctl_t            dist_ctl;
  logic [AW-1:0]                 dist_idx;
  pnc_pkg::rgb_t                 dist_color;
  logic [pnc_pkg::DIST_W-1:0]    dist_d;

  pnc_pkg::rgb_t              query;
  logic [pnc_pkg::DIST_W-1:0] best_d;
  logic [AW-1:0]              best_i;
  pnc_pkg::rgb_t              best_c;

  logic                       take;
  logic [pnc_pkg::DIST_W-1:0] win_d;
  logic [AW-1:0]              win_i;
  logic [IW-1:0]              win_i_w;
  pnc_pkg::rgb_t              win_c;

  pnc_pkg::result_t pend;

  // Index decode: an index at or beyond the palette size is out of range.
  assign item_idx_w    = IW'(item.entry_index);
  assign item_in_range = item_idx_w < IW'(PALETTE_SIZE);
  assign item_addr     = item_idx_w[AW-1:0];
  assign item_wr_hit   = (item.kind == pnc_pkg::KIND_WRITE) && item_in_range;

  assign accept = item_valid && item_ready;
  assign issue  = (state == pnc_pkg::ST_SCAN) && (scan_cnt < CW'(PALETTE_SIZE));

  // Next state and handshake.
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      pnc_pkg::ST_CLEAR: begin
        if (scan_cnt == CW'(PALETTE_SIZE - 1)) begin
          state_next = pnc_pkg::ST_IDLE;
        end
      end
      pnc_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (item.kind)
            pnc_pkg::KIND_FIND: state_next = pnc_pkg::ST_SCAN;
            pnc_pkg::KIND_READ: state_next = item_in_range ? pnc_pkg::ST_READ
                                                           : pnc_pkg::ST_DONE;
            default:            state_next = pnc_pkg::ST_DONE;
          endcase
        end
      end
      pnc_pkg::ST_SCAN: begin
        if (dist_ctl.valid && dist_ctl.last) begin
          state_next = pnc_pkg::ST_DONE;
        end
      end
      pnc_pkg::ST_READ: begin
        state_next = pnc_pkg::ST_DONE;
      end
      pnc_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = pnc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pnc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memory port steering. The clearing pass owns the write port until idle;
  // afterwards only an accepted in-range write uses it. Items run one at a
  // time, so a write and a later read of the same entry never overlap.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_addr;
    mem_wdata = '{red: item.red, green: item.green, blue: item.blue};
    if (state == pnc_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = scan_cnt[AW-1:0];
      mem_wdata = (scan_cnt < CW'(pnc_pkg::BOOT_COUNT)) ?
                  pnc_pkg::BOOT_COLORS[scan_cnt[3:0]] : '0;
    end else if (accept && item.kind == pnc_pkg::KIND_WRITE && item_in_range) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state == pnc_pkg::ST_IDLE) ? item_addr : scan_cnt[AW-1:0];
  end

  pnc_mem #(
    .DEPTH (PALETTE_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pnc_dist #(
    .AW (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (rd_ctl),
    .in_idx    (rd_idx),
    .in_color  (mem_rdata),
    .query     (query),
    .out_ctl   (dist_ctl),
    .out_idx   (dist_idx),
    .out_color (dist_color),
    .out_dist  (dist_d)
  );

  // Running minimum: strict compare keeps the lowest index on a tie. The
  // best distance starts above any reachable value, so entry 0 always wins
  // its first compare.
  always_comb begin
    take    = dist_ctl.valid && (dist_d < best_d);
    win_d   = take ? dist_d : best_d;
    win_i   = take ? dist_idx : best_i;
    win_c   = take ? dist_color : best_c;
    win_i_w = IW'(win_i);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt     <= '0;
      rd_ctl       <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_ctl <= '{valid: issue, last: issue && (scan_cnt == CW'(PALETTE_SIZE - 1))};
      if (state == pnc_pkg::ST_CLEAR || issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else if (accept) begin
        scan_cnt <= '0;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[AW-1:0];
    if (accept) begin
      query  <= '{red: item.red, green: item.green, blue: item.blue};
      best_d <= '1;
      best_i <= '0;
      best_c <= '0;
      // echo the index; a write that lands also returns the stored color
      pend   <= '{found_index:   item.entry_index,
                  best_distance: '0,
                  red_out:       item_wr_hit ? item.red : 8'd0,
                  green_out:     item_wr_hit ? item.green : 8'd0,
                  blue_out:      item_wr_hit ? item.blue : 8'd0};
    end else begin
      if (take) begin
        best_d <= dist_d;
        best_i <= dist_idx;
        best_c <= dist_color;
      end
      if (state == pnc_pkg::ST_SCAN && dist_ctl.valid && dist_ctl.last) begin
        pend.found_index   <= win_i_w[7:0];
        pend.best_distance <= win_d;
        pend.red_out       <= win_c.red;
        pend.green_out     <= win_c.green;
        pend.blue_out      <= win_c.blue;
      end
      if (state == pnc_pkg::ST_READ) begin
        pend.red_out   <= mem_rdata.red;
        pend.green_out <= mem_rdata.green;
        pend.blue_out  <= mem_rdata.blue;
      end
    end
    if (load_out) begin
      result <= pend;
    end
  end

  // A new item finds the search pipeline empty.
  a_pipe_empty_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !rd_ctl.valid && !dist_ctl.valid)
    else $error("search pipeline busy when an item was accepted");

  // Distance results only appear while a search is running.
  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dist_ctl.valid |-> state == pnc_pkg::ST_SCAN)
    else $error("distance beat outside a search");

  // The palette is never written while it is being searched.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != pnc_pkg::ST_SCAN)
    else $error("palette written during a search");

  // A delivered distance never exceeds the largest RGB888 distance.
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.best_distance <= pnc_pkg::MAX_DIST)
    else $error("result distance out of range");

endmodule

// ===== bench/palette_nearest_color_tb.sv =====
// Self-checking testbench for the palette nearest-color block, with its own palette model.
`timescale 1ns / 1ps

module palette_nearest_color_tb;

  // Match the block's default palette depth; the model below handles any depth.
  localparam int PAL_ENTRIES = pnc_pkg::PALETTE_SIZE_DEF;

  // The package names three kinds; the fourth encoding is the unused one.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int TOTAL_BEATS = 950;
  localparam int PHASE_B_AT  = 320;  // sender idles more, receiver less
  localparam int PHASE_C_AT  = 640;  // nobody idles; long receiver hold-off here
  localparam int HOLD_CYCLES = 800;
  localparam int MAX_REPORTS = 10;

  // One row of the opening script. Rows with a typed answer are checked against
  // that answer; the rest are checked against the model.
  typedef struct packed {
    pnc_pkg::item_t   stim;
    bit               typed;
    pnc_pkg::result_t want;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t OPENING_ROWS [SCRIPT_LEN] = '{
    // Reset contents: first, a standard color, last standard color, top entry.
    '{{pnc_pkg::KIND_READ,  8'd0,   24'h000000}, 1'b1, {8'd0,   18'd0, 24'h000000}},
    '{{pnc_pkg::KIND_READ,  8'd1,   24'h000000}, 1'b1, {8'd1,   18'd0, 24'hFFFFFF}},
    '{{pnc_pkg::KIND_READ,  8'd15,  24'hFFFFFF}, 1'b1, {8'd15,  18'd0, 24'h800080}},
    '{{pnc_pkg::KIND_READ,  8'd255, 24'hFFFFFF}, 1'b1, {8'd255, 18'd0, 24'h000000}},
    // Exact hits on the reset palette.
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h000000}, 1'b1, {8'd0,   18'd0, 24'h000000}},
    '{{pnc_pkg::KIND_FIND,  8'd255, 24'hFFFFFF}, 1'b1, {8'd1,   18'd0, 24'hFFFFFF}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'hFF0000}, 1'b1, {8'd4,   18'd0, 24'hFF0000}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h808080}, 1'b1, {8'd3,   18'd0, 24'h808080}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h00FFFF}, 1'b1, {8'd12,  18'd0, 24'h00FFFF}},
    // Near misses, left to the model.
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h010203}, 1'b0, '0},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h7F7F80}, 1'b0, '0},
    // Unused kind: echo the index, everything else zero, palette untouched.
    '{{KIND_SPARE,          8'hAA,  24'hFFFFFF}, 1'b1, {8'hAA,  18'd0, 24'h000000}},
    '{{KIND_SPARE,          8'h00,  24'h000000}, 1'b1, {8'h00,  18'd0, 24'h000000}},
    // Duplicate white at the top entry: the tie must go to entry 1.
    '{{pnc_pkg::KIND_WRITE, 8'd255, 24'hFFFFFF}, 1'b1, {8'd255, 18'd0, 24'hFFFFFF}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'hFFFFFF}, 1'b1, {8'd1,   18'd0, 24'hFFFFFF}},
    // Move black off entry 0; the first black is then entry 16.
    '{{pnc_pkg::KIND_WRITE, 8'd0,   24'h7F7F7F}, 1'b1, {8'd0,   18'd0, 24'h7F7F7F}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h000000}, 1'b0, '0},
    '{{pnc_pkg::KIND_WRITE, 8'd128, 24'h123456}, 1'b1, {8'd128, 18'd0, 24'h123456}},
    '{{pnc_pkg::KIND_READ,  8'd128, 24'h000000}, 1'b1, {8'd128, 18'd0, 24'h123456}},
    '{{pnc_pkg::KIND_FIND,  8'd7,   24'h123457}, 1'b0, '0},
    // Drop white from entry 1 so the top entry wins white.
    '{{pnc_pkg::KIND_WRITE, 8'd1,   24'h000000}, 1'b1, {8'd1,   18'd0, 24'h000000}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'hFFFFFF}, 1'b0, '0},
    '{{pnc_pkg::KIND_READ,  8'd0,   24'hFFFFFF}, 1'b1, {8'd0,   18'd0, 24'h7F7F7F}},
    '{{pnc_pkg::KIND_FIND,  8'd0,   24'h40C020}, 1'b0, '0},
    '{{pnc_pkg::KIND_WRITE, 8'd254, 24'hAA55CC}, 1'b1, {8'd254, 18'd0, 24'hAA55CC}}
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  pnc_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  pnc_pkg::result_t result;

  // Side channel that travels with each beat: a typed answer, if any.
  bit               typed_beat;
  pnc_pkg::result_t typed_answer;

  pnc_pkg::rgb_t    palette_copy [PAL_ENTRIES];
  pnc_pkg::result_t answers_due [$];

  int      beats_sent  = 0;
  int      mismatches  = 0;
  int      tx_idle_pct = 24;
  int      rx_idle_pct = 50;
  bit      hold_asked  = 1'b0;

  palette_nearest_color #(
    .PALETTE_SIZE(PAL_ENTRIES)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Answer one beat and apply its side effect on the palette copy. The scan
  // starts with an impossible distance so entry 0 always takes the lead, and a
  // later entry only takes over when strictly nearer: ties stay with the lowest.
  function automatic pnc_pkg::result_t lookup_answer(pnc_pkg::item_t beat);
    pnc_pkg::result_t ans;
    int               dr, dg, db;
    int unsigned      gap, best_gap;
    int               best_at;
    bit               in_range;
    ans = '0;
    ans.found_index = beat.entry_index;
    in_range = int'(beat.entry_index) < PAL_ENTRIES;
    case (beat.kind)
      pnc_pkg::KIND_FIND: begin
        best_gap = 32'hFFFF_FFFF;
        best_at = 0;
        for (int i = 0; i < PAL_ENTRIES; i++) begin
          dr = int'(palette_copy[i].red) - int'(beat.red);
          dg = int'(palette_copy[i].green) - int'(beat.green);
          db = int'(palette_copy[i].blue) - int'(beat.blue);
          gap = dr * dr + dg * dg + db * db;
          if (gap < best_gap) begin
            best_gap = gap;
            best_at = i;
          end
        end
        ans.found_index = 8'(best_at);
        ans.best_distance = pnc_pkg::DIST_W'(best_gap);
        {ans.red_out, ans.green_out, ans.blue_out} = palette_copy[best_at];
      end
      pnc_pkg::KIND_WRITE: begin
        // Entries from 256 up cannot be addressed, so only low entries change.
        if (in_range) begin
          palette_copy[beat.entry_index] = {beat.red, beat.green, beat.blue};
          {ans.red_out, ans.green_out, ans.blue_out} = palette_copy[beat.entry_index];
        end
      end
      pnc_pkg::KIND_READ: begin
        if (in_range) begin
          {ans.red_out, ans.green_out, ans.blue_out} = palette_copy[beat.entry_index];
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic pnc_pkg::item_t beat_of(logic [1:0] kind, logic [7:0] slot,
                                             pnc_pkg::rgb_t color);
    pnc_pkg::item_t b;
    b.kind = kind;
    b.entry_index = slot;
    {b.red, b.green, b.blue} = color;
    return b;
  endfunction

  function automatic pnc_pkg::rgb_t rand_color();
    return pnc_pkg::rgb_t'(24'($urandom));
  endfunction

  // Shift one channel by up to three steps, clamped to the channel range.
  function automatic logic [7:0] nudge(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic pnc_pkg::rgb_t jitter(pnc_pkg::rgb_t c);
    pnc_pkg::rgb_t j;
    j.red = nudge(c.red);
    j.green = nudge(c.green);
    j.blue = nudge(c.blue);
    return j;
  endfunction

  // Offer one beat: idle first at the phase's rate, then hold valid and the
  // payload until the block takes it. Valid is only lowered by a later idle,
  // so back-to-back beats keep it high without a dip.
  task automatic send_beat(pnc_pkg::item_t beat, bit typed = 1'b0,
                           pnc_pkg::result_t want = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    item         <= beat;
    typed_beat   <= typed;
    typed_answer <= want;
    do @(posedge clk); while (!item_ready);
    beats_sent++;
    if (beats_sent == PHASE_B_AT) begin
      tx_idle_pct = 50;
      rx_idle_pct <= 24;
    end
    if (beats_sent == PHASE_C_AT) begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      hold_asked <= 1'b1;
    end
  endtask

  task automatic note_mismatch(string what, pnc_pkg::result_t want,
                               pnc_pkg::result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s: want idx=%0d dist=%0d rgb=%02h%02h%02h,",
               $realtime, what, want.found_index, want.best_distance,
               want.red_out, want.green_out, want.blue_out,
               " got idx=%0d dist=%0d rgb=%02h%02h%02h",
               got.found_index, got.best_distance,
               got.red_out, got.green_out, got.blue_out);
    end
  endtask

  // Input side: every accepted beat gets its answer queued, in order.
  always @(posedge clk) begin : take_beat
    pnc_pkg::result_t computed;
    if (!rst && item_valid && item_ready) begin
      computed = lookup_answer(item);
      answers_due.push_back(typed_beat ? typed_answer : computed);
    end
  end

  // Output side: compare each accepted result with the oldest answer.
  always @(posedge clk) begin : take_result
    pnc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, result);
      end else begin
        want = answers_due.pop_front();
        if (result.found_index !== want.found_index
            || result.best_distance !== want.best_distance
            || result.red_out !== want.red_out
            || result.green_out !== want.green_out
            || result.blue_out !== want.blue_out) begin
          note_mismatch("result mismatch", want, result);
        end
      end
    end
  end

  // Receiver: random ready at the phase's idle rate. Once asked, hold ready
  // low for a long stretch so the result register and the engine both fill
  // and the block has to stall the item channel.
  initial begin : receiver
    bit held;
    held = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked && !held) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : stimulus
    pnc_pkg::rgb_t base;
    logic [7:0]    slot;
    int            pick;
    int            nwrites;

    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    typed_beat   = 1'b0;
    typed_answer = '0;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      palette_copy[i] = (i < pnc_pkg::BOOT_COUNT) ? pnc_pkg::BOOT_COLORS[i]
                                                  : pnc_pkg::rgb_t'(24'h000000);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Opening script. The block is still clearing for a while after reset;
    // the handshake simply waits that out.
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      send_beat(OPENING_ROWS[r].stim, OPENING_ROWS[r].typed, OPENING_ROWS[r].want);
    end

    // Flood the palette with black, then ask for white: the largest possible
    // distance, won by entry 0.
    for (int i = 0; i < 256; i++) begin
      send_beat(beat_of(pnc_pkg::KIND_WRITE, 8'(i), 24'h000000));
    end
    send_beat(beat_of(pnc_pkg::KIND_FIND, 8'hFF, 24'hFFFFFF), 1'b1,
              {8'd0, pnc_pkg::MAX_DIST, 24'h000000});

    // Refill with random colors so the searches below have real competition.
    for (int i = 0; i < 256; i++) begin
      send_beat(beat_of(pnc_pkg::KIND_WRITE, 8'(i), rand_color()));
    end

    // Random part. Clusters plant one color (some copies exact, some jittered)
    // at a few entries and then look for something close to it, which drives
    // ties and near ties through the search; the rest is loose traffic.
    while (beats_sent < TOTAL_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        base = rand_color();
        nwrites = $urandom_range(1, 3);
        slot = 8'($urandom);
        for (int k = 0; k < nwrites; k++) begin
          slot = 8'($urandom);
          send_beat(beat_of(pnc_pkg::KIND_WRITE, slot,
                            $urandom_range(1) ? base : jitter(base)));
        end
        send_beat(beat_of(pnc_pkg::KIND_FIND, 8'($urandom),
                          $urandom_range(1) ? base : jitter(base)));
        if ($urandom_range(1)) begin
          send_beat(beat_of(pnc_pkg::KIND_READ, slot, rand_color()));
        end
      end else if (pick < 60) begin
        send_beat(beat_of(pnc_pkg::KIND_FIND, 8'($urandom), rand_color()));
      end else if (pick < 75) begin
        send_beat(beat_of(pnc_pkg::KIND_WRITE, 8'($urandom), rand_color()));
      end else if (pick < 90) begin
        send_beat(beat_of(pnc_pkg::KIND_READ, 8'($urandom), rand_color()));
      end else begin
        send_beat(beat_of(KIND_SPARE, 8'($urandom), rand_color()));
      end
    end

    // Drain: drop valid, let the receiver take everything, then keep clocking
    // so that anything stray still shows up.
    item_valid <= 1'b0;
    rx_idle_pct <= 0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (PAL_ENTRIES + 16) @(posedge clk);

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pnc_pkg.sv
rtl/core/pnc_mem.sv
rtl/core/pnc_dist.sv
rtl/core/palette_nearest_color.sv
bench/palette_nearest_color_tb.sv
